### src/tarx_pkg.sv
// Shared types and constants for the tar member extractor.
package tarx_pkg;

  localparam int unsigned MAX_NAME_BYTES = 56;
  localparam int unsigned NAME_WORDS     = 7;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [8:0] SIZE_FIRST  = 9'd124;
  localparam logic [8:0] SIZE_LAST   = 9'd135;
  localparam logic [8:0] HEADER_LAST = 9'd511;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_WORD0  = 3'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_DATA   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_END_MARKER = 3'd2,
    ST_STREAM_END = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_e;

  // Controls from the header walker to the size field decoder.
  typedef struct packed {
    logic step;   // a size field byte is consumed
    logic first;  // it is the first byte of the field
    logic clear;  // header done or stream end
  } size_ctl_t;

endpackage

### src/tarx_size_dec.sv
// Size field decoder: base-256 or octal, one byte per step.
module tarx_size_dec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tarx_pkg::size_ctl_t ctl_i,
  input  logic [7:0]        byte_i,
  output logic [63:0]       size_o
);

  logic [63:0] size_q, size_d;
  logic        bin_q, bin_d;
  logic        started_q, started_d;
  logic        ended_q, ended_d;
  logic        blank;
  logic [63:0] digit;

  assign blank = (byte_i == 8'h00) || (byte_i == tarx_pkg::ASCII_SPACE);
  // wraps at 64 bits for bytes below ASCII zero
  assign digit = {56'd0, byte_i} - {56'd0, tarx_pkg::ASCII_ZERO};

  always_comb begin
    size_d    = size_q;
    bin_d     = bin_q;
    started_d = started_q;
    ended_d   = ended_q;
    if (ctl_i.clear) begin
      size_d    = '0;
      bin_d     = 1'b0;
      started_d = 1'b0;
      ended_d   = 1'b0;
    end else if (ctl_i.step) begin
      if (ctl_i.first && byte_i[7]) begin
        bin_d     = 1'b1;
        started_d = 1'b0;
        ended_d   = 1'b0;
        size_d    = {57'd0, byte_i[6:0]};
      end else if (bin_q) begin
        size_d = {size_q[55:0], byte_i};
      end else if (!ended_q) begin
        if (!started_q) begin
          if (!blank) begin
            started_d = 1'b1;
            size_d    = digit;
          end
        end else if (blank) begin
          ended_d = 1'b1;
        end else begin
          size_d = {size_q[60:0], 3'b000} + digit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= '0;
      bin_q     <= 1'b0;
      started_q <= 1'b0;
      ended_q   <= 1'b0;
    end else begin
      size_q    <= size_d;
      bin_q     <= bin_d;
      started_q <= started_d;
      ended_q   <= ended_d;
    end
  end

  assign size_o = size_q;

endmodule

### src/tar_member_extractor.sv
// Top level: streams a tar archive and passes on the data of one named member.
// An accepted archive word's result word is registered and shown in the cycle after.
// One archive word per cycle while not stalled; a single registered pass over the
// header walker, size decoder and countdown, with one output register.
// Reset: asynchronous, active low; clears the walker state and the name
// registers. end_of_stream also returns the walker state to its reset value.
module tar_member_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  archive_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tarx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // configuration
  logic [5:0]  name_len_q;
  logic [63:0] name_word_q [tarx_pkg::NAME_WORDS];
  logic [7:0]  name_byte [tarx_pkg::MAX_NAME_BYTES];
  logic [5:0]  len_eff;

  // walker state
  tarx_pkg::phase_e phase_q, phase_d;
  logic [8:0]  hpos_q, hpos_d;
  logic        mism_q, mism_d;
  logic        nend_q, nend_d;
  logic        nonzero_q, nonzero_d;
  logic        pzero_q, pzero_d;
  logic [63:0] count_q, count_d;

  // size decoder
  tarx_pkg::size_ctl_t size_ctl;
  logic [63:0] size_val;

  // per-word result
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_bv;
  logic        res_last;
  tarx_pkg::status_e res_status;

  logic        in_acc;
  logic        hdr_end;
  logic        mism_eff;
  logic        nonzero_eff;
  logic        zero_block;
  logic [63:0] size_rnd;
  logic [63:0] skip_cnt;
  logic [63:0] count_dec;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_bv_q;
  logic        out_last_q;
  logic [2:0]  out_status_q;
  logic        out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q <= '0;
      for (int i = 0; i < tarx_pkg::NAME_WORDS; i++) name_word_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tarx_pkg::CFG_NAME_LENGTH) begin
        name_len_q <= cfg_data_i[5:0];
      end else begin
        name_word_q[cfg_index_i - tarx_pkg::CFG_NAME_WORD0] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < tarx_pkg::MAX_NAME_BYTES; k++) begin
      name_byte[k] = name_word_q[k / 8][(k % 8) * 8 +: 8];
    end
  end

  assign len_eff = (name_len_q > 6'(tarx_pkg::MAX_NAME_BYTES)) ?
                   6'(tarx_pkg::MAX_NAME_BYTES) : name_len_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign hdr_end     = (phase_q == tarx_pkg::PH_HEADER) && (hpos_q == tarx_pkg::HEADER_LAST);
  assign nonzero_eff = nonzero_q || (archive_byte_i != 8'h00);
  // the name field never reaches the last header byte, so the stored flag is final
  assign mism_eff    = mism_q;
  assign zero_block  = (size_val == '0) && !nonzero_eff;

  // skip length rounded up to the block size, saturating
  assign size_rnd  = size_val + 64'd511;
  assign skip_cnt  = (size_val > ~64'h1FF) ? '1 : {size_rnd[63:9], 9'd0};
  assign count_dec = count_q - 64'd1;

  always_comb begin
    size_ctl.step  = in_acc && (phase_q == tarx_pkg::PH_HEADER) &&
                     (hpos_q inside {[tarx_pkg::SIZE_FIRST:tarx_pkg::SIZE_LAST]});
    size_ctl.first = (hpos_q == tarx_pkg::SIZE_FIRST);
    size_ctl.clear = in_acc && (end_of_stream_i || hdr_end);
  end

  tarx_size_dec u_size_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (size_ctl),
    .byte_i (archive_byte_i),
    .size_o (size_val)
  );

  // next state
  always_comb begin
    phase_d   = phase_q;
    hpos_d    = hpos_q;
    mism_d    = mism_q;
    nend_d    = nend_q;
    nonzero_d = nonzero_q;
    pzero_d   = pzero_q;
    count_d   = count_q;
    if (in_acc) begin
      case (phase_q)
        tarx_pkg::PH_HEADER: begin
          nonzero_d = nonzero_eff;
          if ((hpos_q < {3'd0, len_eff}) && !mism_q && !nend_q) begin
            if (archive_byte_i != name_byte[hpos_q[5:0]]) begin
              mism_d = 1'b1;
            end else if (archive_byte_i == 8'h00) begin
              nend_d = 1'b1;
            end
          end
          if (hdr_end) begin
            hpos_d    = '0;
            mism_d    = 1'b0;
            nend_d    = 1'b0;
            nonzero_d = 1'b0;
            if (!mism_eff) begin
              if (size_val == '0) begin
                phase_d = tarx_pkg::PH_DONE;
              end else begin
                count_d = size_val;
                phase_d = tarx_pkg::PH_DATA;
              end
            end else if (zero_block && pzero_q) begin
              phase_d = tarx_pkg::PH_DONE;
            end else begin
              pzero_d = zero_block;
              count_d = skip_cnt;
              phase_d = (skip_cnt != '0) ? tarx_pkg::PH_SKIP : tarx_pkg::PH_HEADER;
            end
          end else begin
            hpos_d = hpos_q + 9'd1;
          end
        end
        tarx_pkg::PH_SKIP: begin
          count_d = count_dec;
          if (count_dec == '0) phase_d = tarx_pkg::PH_HEADER;
        end
        tarx_pkg::PH_DATA: begin
          count_d = count_dec;
          if (count_dec == '0) phase_d = tarx_pkg::PH_DONE;
        end
        default: ;
      endcase
      if (end_of_stream_i) begin
        phase_d   = tarx_pkg::PH_HEADER;
        hpos_d    = '0;
        mism_d    = 1'b0;
        nend_d    = 1'b0;
        nonzero_d = 1'b0;
        pzero_d   = 1'b0;
        count_d   = '0;
      end
    end
  end

  // result of the accepted word
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = 8'h00;
    res_bv     = 1'b0;
    res_last   = 1'b0;
    res_status = tarx_pkg::ST_DATA;
    case (phase_q)
      tarx_pkg::PH_HEADER: begin
        if (hdr_end && !mism_eff && (size_val == '0)) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          res_status = tarx_pkg::ST_COMPLETE;
        end else if (hdr_end && mism_eff && zero_block && pzero_q) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          res_status = tarx_pkg::ST_END_MARKER;
        end else if (end_of_stream_i) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          // matched on this word with data owed
          res_status = (hdr_end && !mism_eff) ? tarx_pkg::ST_TRUNCATED :
                                                tarx_pkg::ST_STREAM_END;
        end
      end
      tarx_pkg::PH_SKIP: begin
        if (end_of_stream_i) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          res_status = tarx_pkg::ST_STREAM_END;
        end
      end
      tarx_pkg::PH_DATA: begin
        res_valid = 1'b1;
        res_byte  = archive_byte_i;
        res_bv    = 1'b1;
        if (count_dec == '0) begin
          res_last = 1'b1;
        end else if (end_of_stream_i) begin
          res_last   = 1'b1;
          res_status = tarx_pkg::ST_TRUNCATED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tarx_pkg::PH_HEADER;
      hpos_q    <= '0;
      mism_q    <= 1'b0;
      nend_q    <= 1'b0;
      nonzero_q <= 1'b0;
      pzero_q   <= 1'b0;
      count_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      hpos_q    <= hpos_d;
      mism_q    <= mism_d;
      nend_q    <= nend_d;
      nonzero_q <= nonzero_d;
      pzero_q   <= pzero_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_acc && res_valid) begin
      out_byte_q   <= res_byte;
      out_bv_q     <= res_bv;
      out_last_q   <= res_last;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bv_q;
  assign last_o       = out_last_q;
  assign status_o     = out_status_q;

`ifndef SYNTH
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tarx_pkg::PH_DATA) |-> (count_q != '0))
    else $error("data phase with zero count");

  a_skip_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tarx_pkg::PH_SKIP) |-> (count_q != '0))
    else $error("skip phase with zero count");

  a_hpos_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hpos_q != '0) |-> (phase_q == tarx_pkg::PH_HEADER))
    else $error("header position off header phase");

  a_eos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_stream_i) |=>
      ((phase_q == tarx_pkg::PH_HEADER) && (hpos_q == '0) && !pzero_q))
    else $error("no restart after stream end");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |->
      ((status_o == tarx_pkg::ST_DATA) || (status_o == tarx_pkg::ST_TRUNCATED)))
    else $error("data word with wrong status");
`endif

endmodule
